@@ sv/oaht_pkg.sv @@
// ---------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants for the open-addressing hash table: table
// geometry, operation and condition codes, transaction payloads.
// ---------------------------------------------------------------------------
`default_nettype none

package oaht_pkg;

  localparam int SLOTS     = 1024;
  localparam int KEY_BITS  = 64;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = 11;
  localparam int RUNS_W    = 16;
  localparam int THRESHOLD = 2;
  // Load above 70 percent: live * 10 > SLOTS * 7.
  localparam int LOAD_LIMIT = SLOTS * 7;

  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  localparam logic [2:0] COND_EMPTY    = 3'd0;
  localparam logic [2:0] COND_FOUND    = 3'd1;
  localparam logic [2:0] COND_FULL     = 3'd2;
  localparam logic [2:0] COND_INSERTED = 3'd3;
  localparam logic [2:0] COND_REMOVED  = 3'd4;

  localparam logic REG_LONG_PROBE_LIMIT = 1'b0;
  localparam logic [RUNS_W-1:0] LIMIT_RESET = 16'd16;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key_tag;
    logic [31:0] primary_hash;
    logic [31:0] secondary_hash;
    logic [9:0]  delete_slot;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  slot_index;
    logic [2:0]  condition;
    logic [63:0] stored_key;
    logic [10:0] entry_count;
    logic [10:0] max_probe_length;
    logic        grow_advised;
  } out_result_t;

  typedef struct packed {
    logic                used;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

endpackage

`default_nettype wire

@@ sv/oaht_mem.sv @@
// ---------------------------------------------------------------------------
// oaht_mem
// Slot store: one entry per slot holding the in-use flag and the key. One
// write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module oaht_mem (
  input  wire logic                  clk,
  input  wire oaht_pkg::mem_wr_t     wr,
  input  wire logic                  rd_en,
  input  wire logic [oaht_pkg::SLOT_W-1:0] rd_addr,
  output oaht_pkg::entry_t           rd_data
);
  import oaht_pkg::*;

  entry_t mem [SLOTS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ sv/open_addressing_hash_table.sv @@
// ---------------------------------------------------------------------------
// open_addressing_hash_table
// Fixed-size key table with a primary slot check and triangular quadratic
// probing; insert, search and slot delete with load and probe statistics.
// ---------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; its result
// appears on out_result for exactly one cycle with out_valid high and
// cannot be stalled. Each operation costs one read of the slot store per
// slot visited: a delete, or a search or insert settled at the primary
// slot, passes through ST_PRIM alone before the next acceptance, and
// each quadratic probe adds a pass through ST_PROBE, so the worst case
// walks the whole table. After reset the store is swept clear one
// slot per cycle, with busy held high; register writes are taken
// during the sweep.
// ---------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_table (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire oaht_pkg::in_item_t     in_item,
  output logic                        out_valid,
  output oaht_pkg::out_result_t       out_result,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import oaht_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRIM,
    ST_PROBE
  } state_t;

  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [RUNS_W-1:0] RUNS_MAX  = '1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   clr_r, clr_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [SLOT_W-1:0]   base_r, base_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOT_W-1:0]   k_r, k_nxt;
  logic [SLOT_W-1:0]   off_r, off_nxt;
  logic [CNT_W-1:0]    live_r, live_nxt;
  logic [RUNS_W-1:0]   runs_r, runs_nxt;
  logic [CNT_W-1:0]    longest_r, longest_nxt;
  logic [RUNS_W-1:0]   limit_r, limit_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_result_t         out_r, out_nxt;

  mem_wr_t             wr;
  logic                rd_en;
  logic [SLOT_W-1:0]   rd_addr;
  entry_t              ent;

  logic                hit;
  logic [SLOT_W:0]     kp1;
  logic                done;
  logic [2:0]          cond;
  logic [SLOT_W-1:0]   res_slot;
  logic [KEY_BITS-1:0] shown;

  oaht_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ent)
  );

  assign hit = ent.used && (ent.key == key_r);
  assign kp1 = (SLOT_W + 1)'(k_r) + (SLOT_W + 1)'(1);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    base_nxt      = base_r;
    slot_nxt      = slot_r;
    k_nxt         = k_r;
    off_nxt       = off_r;
    live_nxt      = live_r;
    runs_nxt      = runs_r;
    longest_nxt   = longest_r;
    limit_nxt     = limit_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr            = '0;
    rd_en         = 1'b0;
    rd_addr       = slot_r;
    done          = 1'b0;
    cond          = COND_EMPTY;
    res_slot      = slot_r;
    shown         = key_r;

    if (psel && penable && pwrite && (paddr[2] == REG_LONG_PROBE_LIMIT)) begin
      limit_nxt = pwdata[RUNS_W-1:0];
    end

    case (state_r)
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_r;
        wr.data = '0;
        clr_nxt = clr_r + SLOT_W'(1);
        if (clr_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          mode_nxt = in_item.mode;
          key_nxt  = in_item.key_tag[KEY_BITS-1:0];
          base_nxt = in_item.secondary_hash[SLOT_W-1:0];
          if (in_item.mode == MODE_DELETE) begin
            slot_nxt = SLOT_W'(in_item.delete_slot);
          end else begin
            slot_nxt = in_item.primary_hash[SLOT_W-1:0];
          end
          rd_en     = 1'b1;
          rd_addr   = slot_nxt;
          state_nxt = ST_PRIM;
        end
      end
      ST_PRIM: begin
        if (mode_r == MODE_DELETE) begin
          done    = 1'b1;
          cond    = COND_REMOVED;
          wr.en   = 1'b1;
          wr.addr = slot_r;
          wr.data = '0;
          if (ent.used) begin
            shown = ent.key;
            if (live_r != '0) begin
              live_nxt = live_r - CNT_W'(1);
            end
          end
        end else if (!ent.used || hit) begin
          done = 1'b1;
        end else begin
          k_nxt     = '0;
          off_nxt   = '0;
          slot_nxt  = base_r;
          rd_en     = 1'b1;
          rd_addr   = base_r;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (!ent.used) begin
          done = 1'b1;
          if ((k_r > SLOT_W'(THRESHOLD)) && (runs_r != RUNS_MAX)) begin
            runs_nxt = runs_r + RUNS_W'(1);
          end
          if (kp1 > longest_r) begin
            longest_nxt = (kp1 > COUNT_MAX) ? COUNT_MAX : CNT_W'(kp1);
          end
        end else if (hit) begin
          done = 1'b1;
        end else if (k_r == LAST_SLOT) begin
          done     = 1'b1;
          cond     = COND_FULL;
          res_slot = '0;
        end else begin
          // Triangular offsets: offset(k+1) = offset(k) + (k + 1).
          k_nxt    = k_r + SLOT_W'(1);
          off_nxt  = off_r + SLOT_W'(kp1);
          slot_nxt = base_r + off_nxt;
          rd_en    = 1'b1;
          rd_addr  = slot_nxt;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Search and insert share the settling of a finished walk.
    if (done && (mode_r != MODE_DELETE) && (cond != COND_FULL)) begin
      if (hit) begin
        cond  = COND_FOUND;
        shown = ent.key;
      end else if (mode_r == MODE_INSERT) begin
        cond         = COND_INSERTED;
        wr.en        = 1'b1;
        wr.addr      = slot_r;
        wr.data.used = 1'b1;
        wr.data.key  = key_r;
        if (live_r != COUNT_MAX) begin
          live_nxt = live_r + CNT_W'(1);
        end
      end else begin
        cond = COND_EMPTY;
      end
    end

    if (done) begin
      state_nxt                = ST_IDLE;
      out_valid_nxt            = 1'b1;
      out_nxt.slot_index       = 10'(res_slot);
      out_nxt.condition        = cond;
      out_nxt.stored_key       = 64'(shown);
      out_nxt.entry_count      = live_nxt;
      out_nxt.max_probe_length = longest_nxt;
      out_nxt.grow_advised     = (runs_nxt > limit_r) &&
                                 ((32'(live_nxt) * 32'd10) > 32'(LOAD_LIMIT));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      live_r      <= '0;
      runs_r      <= '0;
      longest_r   <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      live_r      <= live_nxt;
      runs_r      <= runs_nxt;
      longest_r   <= longest_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r <= mode_nxt;
    key_r  <= key_nxt;
    base_r <= base_nxt;
    slot_r <= slot_nxt;
    k_r    <= k_nxt;
    off_r  <= off_nxt;
    out_r  <= out_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;
  assign pready     = 1'b1;

  always_comb begin
    if (paddr[2] == REG_LONG_PROBE_LIMIT) begin
      prdata = 32'(limit_r);
    end else begin
      prdata = '0;
    end
  end

endmodule

`default_nettype wire

@@ sv/oaht_checker.sv @@
// ---------------------------------------------------------------------------
// oaht_checker
// Port-level checks on the hash table: result spacing, acceptance and the
// consistency of reported conditions.
// ---------------------------------------------------------------------------
`default_nettype none

module oaht_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  out_valid,
  input wire oaht_pkg::out_result_t out_result
);
  import oaht_pkg::*;

  // An accepted transaction keeps the block busy while the store is read.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // Every result needs at least one store read, so strobes never abut.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in consecutive cycles");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a transaction in progress");

  a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result.condition == COND_FULL)) |->
      (out_result.slot_index == '0))
    else $error("full condition with a nonzero slot");

  a_grow_needs_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.grow_advised) |->
      ((32'(out_result.entry_count) * 32'd10) > 32'(LOAD_LIMIT)))
    else $error("growth advised at low load");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (.*);

`default_nettype wire

@@ bench/oaht_checker.sv @@
// ---------------------------------------------------------------------------
// oaht_scoreboard
// Watches the operation, result and register ports of the hash table. Each
// accepted operation is run through a behavioral copy of the table and
// its statistics; each result is compared field by field with the oldest
// prediction still waiting.
// ---------------------------------------------------------------------------
module oaht_scoreboard (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  oaht_pkg::in_item_t    in_item,
  input  logic                  out_valid,
  input  oaht_pkg::out_result_t out_result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    mismatches,
  output int                    outstanding
);
  import oaht_pkg::*;

  localparam int unsigned CNT_MAX  = 2**CNT_W - 1;
  localparam int unsigned RUNS_MAX = 2**RUNS_W - 1;
  localparam logic [2:0]  LIMIT_ADDR = {REG_LONG_PROBE_LIMIT, 2'b00};

  logic                used_map  [SLOTS];
  logic [KEY_BITS-1:0] key_store [SLOTS];
  int unsigned         live;
  int unsigned         runs;
  int unsigned         longest;
  logic [RUNS_W-1:0]   probe_limit;
  out_result_t         awaited_results [$];

  // Applies one operation to the shadow table and returns what the block
  // should report for it.
  function automatic out_result_t table_op_result(input in_item_t op);
    out_result_t         res;
    logic [KEY_BITS-1:0] key;
    logic [SLOT_W-1:0]   s;
    logic [2:0]          code;
    logic [31:0]         offset;
    int unsigned         k;
    key = op.key_tag[KEY_BITS-1:0];
    res = '0;
    res.stored_key = key;
    if (op.mode == MODE_DELETE) begin
      s = op.delete_slot[SLOT_W-1:0];
      if (used_map[s]) begin
        res.stored_key = key_store[s];
        if (live > 0) live--;
      end
      used_map[s] = 1'b0;
      code = COND_REMOVED;
    end else begin
      code = COND_FULL;
      s = op.primary_hash[SLOT_W-1:0];
      if (!used_map[s]) begin
        code = COND_EMPTY;
      end else if (key_store[s] == key) begin
        code = COND_FOUND;
      end else begin
        offset = '0;
        for (k = 0; k < SLOTS && code == COND_FULL; k++) begin
          offset += k;
          s = op.secondary_hash[SLOT_W-1:0] + offset[SLOT_W-1:0];
          if (!used_map[s]) begin
            code = COND_EMPTY;
            // Only probes that end on an empty slot feed the statistics.
            if (k > THRESHOLD && runs < RUNS_MAX) runs++;
            if (k + 1 > longest) longest = (k + 1 > CNT_MAX) ? CNT_MAX : k + 1;
          end else if (key_store[s] == key) begin
            code = COND_FOUND;
          end
        end
        if (code == COND_FULL) s = '0;
      end
      if (code == COND_FOUND) begin
        res.stored_key = key_store[s];
      end else if (code == COND_EMPTY && op.mode == MODE_INSERT) begin
        used_map[s]  = 1'b1;
        key_store[s] = key;
        if (live < CNT_MAX) live++;
        code = COND_INSERTED;
      end
    end
    res.slot_index       = s;
    res.condition        = code;
    res.entry_count      = live[CNT_W-1:0];
    res.max_probe_length = longest[CNT_W-1:0];
    res.grow_advised     = (runs > probe_limit) && (live * 10 > LOAD_LIMIT);
    return res;
  endfunction

  function automatic void compare_result(input out_result_t want, input out_result_t got);
    if (got.slot_index !== want.slot_index) begin
      $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
      mismatches++;
    end
    if (got.condition !== want.condition) begin
      $error("condition: expected %0d, got %0d", want.condition, got.condition);
      mismatches++;
    end
    if (got.stored_key !== want.stored_key) begin
      $error("stored_key: expected %h, got %h", want.stored_key, got.stored_key);
      mismatches++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      mismatches++;
    end
    if (got.max_probe_length !== want.max_probe_length) begin
      $error("max_probe_length: expected %0d, got %0d",
             want.max_probe_length, got.max_probe_length);
      mismatches++;
    end
    if (got.grow_advised !== want.grow_advised) begin
      $error("grow_advised: expected %0d, got %0d", want.grow_advised, got.grow_advised);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (used_map[i]) used_map[i] = 1'b0;
      live        = 0;
      runs        = 0;
      longest     = 0;
      probe_limit = LIMIT_RESET;
      mismatches  = 0;
      awaited_results.delete();
    end else begin
      // A result always belongs to an earlier transaction, so it is checked
      // before any operation accepted at the same edge is predicted.
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("result with no transaction pending: slot_index %0d, condition %0d",
                 out_result.slot_index, out_result.condition);
          mismatches++;
        end else begin
          compare_result(awaited_results.pop_front(), out_result);
        end
      end
      if (start && !busy) awaited_results.push_back(table_op_result(in_item));
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
        probe_limit = pwdata[RUNS_W-1:0];
    end
    outstanding = awaited_results.size();
  end

endmodule

@@ bench/open_addressing_hash_table_tb.sv @@
// ---------------------------------------------------------------------------
// open_addressing_hash_table_tb
// Drives the hash table through a directed set of operations and then
// through random phases that fill it to capacity, hit the exhausted-probe
// case and drain it again, under several probe limit settings. Checking is
// done by oaht_scoreboard; this module makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module open_addressing_hash_table_tb;
  import oaht_pkg::*;

  localparam int         CYCLE_LIMIT = 6_000_000;
  localparam logic [2:0] LIMIT_ADDR  = {REG_LONG_PROBE_LIMIT, 2'b00};
  // The spare mode code is handled as a search.
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        start   = 1'b0;
  in_item_t    in_item = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        busy;
  logic        out_valid;
  out_result_t out_result;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          outstanding;
  int          cycle_count = 0;
  bit          steady = 1'b0;
  logic [10:0] latest_count = '0;
  logic [63:0] key_pool [$];

  open_addressing_hash_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  oaht_scoreboard u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_result  (out_result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("open_addressing_hash_table_tb: done, errors");
      $finish;
    end
  end

  // The fill phase stops once the table reports itself full, or after 2 * SLOTS inserts.
  always @(posedge clk) begin
    if (out_valid) latest_count <= out_result.entry_count;
  end

  // Both hashes are derived from the key so that a key searched later
  // follows the same probe path as when it was inserted.
  function automatic logic [31:0] key_hash(input logic [63:0] key, input logic [31:0] salt);
    logic [63:0] h;
    h = (key ^ {salt, ~salt}) * 64'h9E37_79B9_7F4A_7C15;
    return h[63:32] ^ h[31:0];
  endfunction

  function automatic in_item_t keyed_item(input logic [1:0] mode, input logic [63:0] key);
    in_item_t op;
    op.mode           = mode;
    op.key_tag        = key;
    op.primary_hash   = key_hash(key, 32'h0000_0001);
    op.secondary_hash = key_hash(key, 32'h0000_0002);
    op.delete_slot    = 10'($urandom_range(0, SLOTS - 1));
    return op;
  endfunction

  function automatic in_item_t raw_item(input logic [1:0] mode, input logic [63:0] key,
                                        input logic [31:0] ph, input logic [31:0] sh,
                                        input logic [9:0] del);
    in_item_t op;
    op.mode           = mode;
    op.key_tag        = key;
    op.primary_hash   = ph;
    op.secondary_hash = sh;
    op.delete_slot    = del;
    return op;
  endfunction

  // Start stays high between back-to-back transactions; it only drops for
  // an idle gap, so it never sees two assignments in one time step.
  task automatic issue(input in_item_t op);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 16) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= {16'h0000, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_op(input int ins_w, input int del_w);
    in_item_t    op;
    logic [63:0] key;
    int          pick;
    pick = $urandom_range(0, 99);
    key  = {$urandom, $urandom};
    if (pick < ins_w) begin
      key_pool.push_back(key);
      op = keyed_item(MODE_INSERT, key);
    end else if (pick < ins_w + del_w) begin
      op = keyed_item(MODE_DELETE, key);
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 7 && key_pool.size() > 0)
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (pick < 5 || pick == 9) begin
        op = keyed_item(MODE_SEARCH, key);
      end else if (pick < 7) begin
        op = keyed_item(MODE_INSERT, key);
      end else begin
        op = raw_item(2'($urandom_range(0, 3)), key, $urandom, $urandom,
                      10'($urandom_range(0, SLOTS - 1)));
      end
    end
    issue(op);
  endtask

  initial begin
    logic [63:0] key;
    int          fills;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    // Taken while the block is still sweeping its store after reset.
    write_limit(16'h0000);

    // Primary slot hits, key matches on search and insert, probe chains
    // that end at two, three and four steps, deletes of used and unused
    // slots, and the spare mode code.
    issue(raw_item(MODE_SEARCH, '1, '1, '1, '1));
    issue(raw_item(MODE_INSERT, '1, '1, '1, '1));
    issue(raw_item(MODE_INSERT, '0, '0, '0, '0));
    issue(raw_item(MODE_SEARCH, '1, '1, '0, '0));
    issue(raw_item(MODE_INSERT, '1, '1, '0, '0));
    issue(raw_item(MODE_INSERT, 64'h5555_5555_5555_5555, 32'h0000_03FF, '0, '1));
    issue(raw_item(MODE_SEARCH, 64'hAAAA_AAAA_AAAA_AAAA, '0, 32'hFFFF_FC00, '0));
    issue(raw_item(MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, '0, 32'hFFFF_FC00, '0));
    issue(raw_item(MODE_INSERT, 64'h0000_0000_0000_1234, '0, '0, '0));
    issue(raw_item(MODE_SEARCH, 64'h0000_0000_0000_1234, '0, '0, '0));
    issue(raw_item(MODE_DELETE, '0, '0, '0, 10'h3FF));
    issue(raw_item(MODE_DELETE, 64'hDEAD_BEEF_0BAD_F00D, '1, '1, 10'h3FF));
    issue(raw_item(MODE_SPARE, '1, '1, '1, '0));
    issue(raw_item(MODE_DELETE, '1, '1, '1, 10'h000));
    issue(raw_item(MODE_SEARCH, '0, '0, '0, '1));
    issue(raw_item(MODE_DELETE, '0, '0, '0, 10'h200));
    settle();

    write_limit(16'hFFFF);
    repeat (200) random_op(70, 8);
    settle();

    // Fill the table to capacity, starting with a stretch without gaps.
    write_limit(16'($urandom_range(1, 40)));
    steady = 1'b1;
    fills  = 0;
    while (latest_count < SLOTS && fills < 2 * SLOTS) begin
      if (fills == 250) steady = 1'b0;
      key = {$urandom, $urandom};
      key_pool.push_back(key);
      issue(keyed_item(MODE_INSERT, key));
      fills++;
    end
    settle();
    // With every slot taken, unknown keys walk the whole probe sequence.
    key = {$urandom, $urandom};
    issue(keyed_item(MODE_INSERT, key));
    issue(keyed_item(MODE_SEARCH, key));
    issue(raw_item(MODE_SPARE, {$urandom, $urandom}, $urandom, $urandom, '1));
    issue(keyed_item(MODE_SEARCH, key_pool[$urandom_range(0, key_pool.size() - 1)]));
    settle();

    write_limit(LIMIT_RESET);
    repeat (100) random_op(10, 60);
    settle();

    write_limit(16'($urandom_range(0, 16'hFFFF)));
    repeat (60) random_op(40, 20);
    settle();

    repeat (SLOTS + 8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("open_addressing_hash_table_tb: done, clean");
    end else begin
      $display("open_addressing_hash_table_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/oaht_pkg.sv
sv/oaht_mem.sv
sv/open_addressing_hash_table.sv
sv/oaht_checker.sv
bench/oaht_checker.sv
bench/open_addressing_hash_table_tb.sv
